[rtl/core/fcpa_pkg.sv]
`timescale 1ns / 1ps
package fcpa_pkg;

  localparam int DEF_MAX_BLOCKS      = 4;
  localparam int DEF_SLOTS_PER_BLOCK = 256;

  localparam int ACTION_W = 2;
  localparam int BLOCK_W  = 2;
  localparam int SLOT_W   = 8;
  localparam int CPB_W    = 9;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CPB_W-1:0] CPB_RESET = 9'd256;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_RESET = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHUNKS_PER_BLOCK = 1'b0,
    CFG_GROWABLE         = 1'b1
  } cfg_idx_t;

  // One list entry: valid bit plus the chunk it names.
  typedef struct packed {
    logic               valid;
    logic [BLOCK_W-1:0] blk;
    logic [SLOT_W-1:0]  slot;
  } link_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_POP  = 2'b10
  } state_t;

endpackage

[rtl/core/fcpa_if.sv]
`timescale 1ns / 1ps
interface fcpa_req_if import fcpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [BLOCK_W-1:0]  free_block;
  logic [SLOT_W-1:0]   free_slot;

  modport source (output valid, output action, output free_block, output free_slot,
                  input ready);
  modport sink (input valid, input action, input free_block, input free_slot,
                output ready);
endinterface

interface fcpa_rsp_if import fcpa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               ok;
  logic [BLOCK_W-1:0] chunk_block;
  logic [SLOT_W-1:0]  chunk_slot;

  modport source (output valid, output ok, output chunk_block, output chunk_slot,
                  input ready);
  modport sink (input valid, input ok, input chunk_block, input chunk_slot,
                output ready);
endinterface

[rtl/core/fcpa_link_ram.sv]
`timescale 1ns / 1ps
module fcpa_link_ram import fcpa_pkg::*; #(
  parameter int DEPTH  = DEF_MAX_BLOCKS * DEF_SLOTS_PER_BLOCK,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  link_t             wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output link_t             rdata
);

  link_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/fcpa_ctrl.sv]
`timescale 1ns / 1ps
module fcpa_ctrl import fcpa_pkg::*; #(
  parameter int MAX_BLOCKS      = DEF_MAX_BLOCKS,
  parameter int SLOTS_PER_BLOCK = DEF_SLOTS_PER_BLOCK,
  parameter int BLK_LIM         = (MAX_BLOCKS < 4) ? MAX_BLOCKS : 4,
  parameter int SLOT_LIM        = (SLOTS_PER_BLOCK < 256) ? SLOTS_PER_BLOCK : 256,
  parameter int ADDR_W          = $clog2(BLK_LIM * SLOT_LIM)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  fcpa_req_if.sink              req,
  fcpa_rsp_if.source            rsp,
  output logic                  mem_we,
  output logic [ADDR_W-1:0]     mem_waddr,
  output link_t                 mem_wdata,
  output logic                  mem_re,
  output logic [ADDR_W-1:0]     mem_raddr,
  input  link_t                 mem_rdata
);

  state_t             state;
  link_t              head;
  logic [CPB_W-1:0]   frontier_slot;
  logic [BLOCK_W-1:0] current_block;
  logic [CPB_W-1:0]   chunks_per_block;
  logic               growable;

  logic               rsp_valid;
  logic               rsp_ok;
  logic [BLOCK_W-1:0] rsp_block;
  logic [SLOT_W-1:0]  rsp_slot;
  logic               rsp_ok_next;
  logic [BLOCK_W-1:0] rsp_block_next;
  logic [SLOT_W-1:0]  rsp_slot_next;

  logic               fire;
  logic [CPB_W-1:0]   slot_limit;
  logic [BLOCK_W:0]   block_inc;
  logic               free_in_range;

  function automatic logic [ADDR_W-1:0] chunk_addr(logic [BLOCK_W-1:0] b,
                                                   logic [SLOT_W-1:0] s);
    return ADDR_W'(32'(b) * SLOT_LIM + 32'(s));
  endfunction

  assign req.ready = (state == ST_IDLE) && (!rsp_valid || rsp.ready);
  assign fire      = req.valid && req.ready;

  assign rsp.valid       = rsp_valid;
  assign rsp.ok          = rsp_ok;
  assign rsp.chunk_block = rsp_block;
  assign rsp.chunk_slot  = rsp_slot;

  always_comb begin
    if (chunks_per_block == '0) begin
      slot_limit = CPB_W'(1);
    end else if (chunks_per_block > CPB_W'(SLOT_LIM)) begin
      slot_limit = CPB_W'(SLOT_LIM);
    end else begin
      slot_limit = chunks_per_block;
    end
  end

  assign block_inc     = {1'b0, current_block} + (BLOCK_W + 1)'(1);
  assign free_in_range = (32'(req.free_block) < BLK_LIM) &&
                         (32'(req.free_slot) < SLOTS_PER_BLOCK);

  // Link memory: push writes the old head under the freed chunk, pop reads the
  // successor of the head.
  assign mem_we    = fire && (req.action == ACT_FREE) && free_in_range;
  assign mem_waddr = chunk_addr(req.free_block, req.free_slot);
  assign mem_wdata = head;
  assign mem_re    = fire && (req.action == ACT_ALLOC) && head.valid;
  assign mem_raddr = chunk_addr(head.blk, head.slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      chunks_per_block <= CPB_RESET;
      growable         <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CHUNKS_PER_BLOCK) begin
        chunks_per_block <= cfg_data;
      end
      if (cfg_index == CFG_GROWABLE) begin
        growable <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      head          <= '0;
      frontier_slot <= '0;
      current_block <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (fire) begin
            case (req.action)
              ACT_ALLOC: begin
                if (head.valid) begin
                  // hold off the next item until the successor link arrives
                  state <= ST_POP;
                end else if (frontier_slot < slot_limit) begin
                  frontier_slot <= frontier_slot + CPB_W'(1);
                end else if (growable && (32'(block_inc) < BLK_LIM)) begin
                  current_block <= block_inc[BLOCK_W-1:0];
                  frontier_slot <= CPB_W'(1);
                end
              end
              ACT_FREE: begin
                if (free_in_range) begin
                  head <= '{valid: 1'b1, blk: req.free_block, slot: req.free_slot};
                end
              end
              ACT_RESET: begin
                head          <= '0;
                frontier_slot <= '0;
                current_block <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_POP: begin
          head  <= mem_rdata;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    rsp_ok_next    = 1'b1;
    rsp_block_next = '0;
    rsp_slot_next  = '0;
    if (req.action == ACT_ALLOC) begin
      if (head.valid) begin
        rsp_block_next = head.blk;
        rsp_slot_next  = head.slot;
      end else if (frontier_slot < slot_limit) begin
        rsp_block_next = current_block;
        rsp_slot_next  = frontier_slot[SLOT_W-1:0];
      end else if (growable && (32'(block_inc) < BLK_LIM)) begin
        rsp_block_next = block_inc[BLOCK_W-1:0];
      end else begin
        rsp_ok_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_ok    <= rsp_ok_next;
      rsp_block <= rsp_block_next;
      rsp_slot  <= rsp_slot_next;
    end
  end

endmodule

[rtl/core/fixed_chunk_pool_allocator.sv]
`timescale 1ns / 1ps
// Fixed-size chunk allocator over a pool of equal blocks. Each request is an
// allocate, a free or a pool reset and returns exactly one response: ok with
// the chunk's block and slot for an allocate (ok low with zero fields when the
// pool is exhausted), ok with zero fields otherwise. Allocate pops the most
// recently freed chunk first, then takes untouched slots of the current block,
// then, with growable set, moves to the next block. Freed chunks are not
// checked for double free. An allocate that pops the returned list holds off
// the next request until the successor link from the synchronous link memory
// is loaded into the head. A single response register holds the result; a new
// request is taken while idle when that register is empty or its response
// transfers in the same cycle. The link memory needs no clearing after reset,
// so requests are taken from the first cycle after reset. Configuration must
// be written only while idle; the block itself does not enforce this.
module fixed_chunk_pool_allocator import fcpa_pkg::*; #(
  parameter int MAX_BLOCKS      = DEF_MAX_BLOCKS,
  parameter int SLOTS_PER_BLOCK = DEF_SLOTS_PER_BLOCK
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  fcpa_req_if.sink              req,
  fcpa_rsp_if.source            rsp
);

  localparam int BLK_LIM  = (MAX_BLOCKS < 4) ? MAX_BLOCKS : 4;
  localparam int SLOT_LIM = (SLOTS_PER_BLOCK < 256) ? SLOTS_PER_BLOCK : 256;
  localparam int DEPTH    = BLK_LIM * SLOT_LIM;
  localparam int ADDR_W   = $clog2(DEPTH);

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  link_t             mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  link_t             mem_rdata;

  fcpa_ctrl #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK),
    .BLK_LIM         (BLK_LIM),
    .SLOT_LIM        (SLOT_LIM),
    .ADDR_W          (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  fcpa_link_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
